// ===== sv/tss_pkg.sv =====
// ----------------------------------------------------------------------------
// tss_pkg
// Shared types and codes for the TCP server socket sequencer.
// ----------------------------------------------------------------------------
package tss_pkg;

    localparam logic [1:0] KIND_START = 2'd0;
    localparam logic [1:0] KIND_DONE  = 2'd1;
    localparam logic [1:0] KIND_TX    = 2'd2;
    localparam logic [1:0] KIND_DISC  = 2'd3;

    localparam logic [3:0] OP_RD_SR      = 4'd0;
    localparam logic [3:0] OP_WR_CR      = 4'd1;
    localparam logic [3:0] OP_WR_PORT    = 4'd2;
    localparam logic [3:0] OP_WR_MODE    = 4'd3;
    localparam logic [3:0] OP_WR_KEEP    = 4'd4;
    localparam logic [3:0] OP_RD_RXSZ    = 4'd5;
    localparam logic [3:0] OP_RD_RXPTR   = 4'd6;
    localparam logic [3:0] OP_RD_RXBLK   = 4'd7;
    localparam logic [3:0] OP_WR_RXPTR   = 4'd8;
    localparam logic [3:0] OP_RD_CR      = 4'd9;
    localparam logic [3:0] OP_RD_TXFREE  = 4'd10;
    localparam logic [3:0] OP_RD_TXPTR   = 4'd11;
    localparam logic [3:0] OP_WR_TXBLK   = 4'd12;
    localparam logic [3:0] OP_WR_TXPTR   = 4'd13;
    localparam logic [3:0] OP_CLR_SENDOK = 4'd14;
    localparam logic [3:0] OP_NONE       = 4'd15;

    localparam logic [2:0] CMD_CLOSE  = 3'd0;
    localparam logic [2:0] CMD_OPEN   = 3'd1;
    localparam logic [2:0] CMD_LISTEN = 3'd2;
    localparam logic [2:0] CMD_RECV   = 3'd3;
    localparam logic [2:0] CMD_SEND   = 3'd4;

    localparam logic [2:0] EV_NONE = 3'd0;
    localparam logic [2:0] EV_CONN = 3'd1;
    localparam logic [2:0] EV_DISC = 3'd2;
    localparam logic [2:0] EV_RX   = 3'd3;
    localparam logic [2:0] EV_TX   = 3'd4;

    localparam logic [7:0] ST_CLOSED     = 8'h00;
    localparam logic [7:0] ST_INIT       = 8'h13;
    localparam logic [7:0] ST_ESTAB      = 8'h17;
    localparam logic [7:0] ST_CLOSE_WAIT = 8'h1C;

    localparam logic [15:0] MODE_TCP = 16'h0001;

    localparam logic [1:0] REG_LISTEN_PORT = 2'd0;
    localparam logic [1:0] REG_RX_CAPACITY = 2'd1;
    localparam logic [1:0] REG_KEEPALIVE   = 2'd2;

    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] read_value;
        logic [15:0] send_length;
    } t_in_item;

    typedef struct packed {
        logic [3:0]  access_op;
        logic [2:0]  socket_command;
        logic [15:0] access_value;
        logic [15:0] access_length;
        logic [2:0]  event_res;
        logic [15:0] event_length;
        logic        link_up;
        logic        send_ready;
        logic        request_rejected;
    } t_out_item;

    typedef struct packed {
        logic [15:0] listen_port;
        logic [15:0] rx_capacity;
        logic [7:0]  keepalive_interval;
    } t_cfg;

endpackage

// ===== sv/tss_cfg.sv =====
// ----------------------------------------------------------------------------
// tss_cfg
// Configuration register file: listen port, rx capacity, keepalive value.
// ----------------------------------------------------------------------------
module tss_cfg (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cfg_valid,
    input  logic [1:0]    i_cfg_index,
    input  logic [15:0]   i_cfg_data,
    output logic          o_cfg_ready,
    output tss_pkg::t_cfg o_cfg
);
    import tss_pkg::*;

    t_cfg r_cfg;

    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.listen_port        <= 16'd0;
            r_cfg.rx_capacity        <= 16'd2048;
            r_cfg.keepalive_interval <= 8'd2;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_LISTEN_PORT: r_cfg.listen_port        <= i_cfg_data;
                REG_RX_CAPACITY: r_cfg.rx_capacity        <= i_cfg_data;
                REG_KEEPALIVE:   r_cfg.keepalive_interval <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

endmodule

// ===== sv/tss_core.sv =====
// ----------------------------------------------------------------------------
// tss_core
// Socket sequencer state, step logic and result register.
// ----------------------------------------------------------------------------
module tss_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_step,
    input  tss_pkg::t_in_item  i_item,
    input  tss_pkg::t_cfg      i_cfg,
    output tss_pkg::t_out_item o_res
);
    import tss_pkg::*;

    typedef enum logic [4:0] {
        P_MAIN_IDLE, P_MAIN, P_CLOSE, P_CLOSE_WAIT, P_PORT, P_MODE, P_KEEP,
        P_OPEN, P_WAIT_OPEN, P_LISTEN_CMD, P_LISTEN, P_EST, P_RXS1, P_RXS2,
        P_RXPTR, P_RXDATA, P_RXWP, P_RECV, P_RECV_POLL, P_TXF1, P_TXF2,
        P_TXPTR, P_TXDATA, P_TXWP, P_SEND, P_SEND_POLL, P_IRR
    } t_phase;

    t_phase      r_phase, n_phase;
    logic [15:0] r_rx_count, n_rx_count;
    logic [15:0] r_rx_ptr, n_rx_ptr;
    logic [15:0] r_tx_free, n_tx_free;
    logic [15:0] r_tx_ptr, n_tx_ptr;
    logic [15:0] r_tx_len, n_tx_len;
    logic        r_tx_pend, n_tx_pend;
    logic        r_disc_pend, n_disc_pend;
    logic        r_conn, n_conn;
    t_out_item   r_res, n_res;

    logic [15:0] v;
    logic [7:0]  st;
    logic        st_down;

    assign v       = i_item.read_value;
    assign st      = v[7:0];
    assign st_down = (st == ST_CLOSED) || (st == ST_INIT) || (st == ST_CLOSE_WAIT);
    assign o_res   = r_res;

    always_comb begin
        n_phase     = r_phase;
        n_rx_count  = r_rx_count;
        n_rx_ptr    = r_rx_ptr;
        n_tx_free   = r_tx_free;
        n_tx_ptr    = r_tx_ptr;
        n_tx_len    = r_tx_len;
        n_tx_pend   = r_tx_pend;
        n_disc_pend = r_disc_pend;
        n_conn      = r_conn;
        n_res       = '0;
        n_res.access_op = OP_NONE;

        unique case (i_item.kind)
            KIND_START: begin
                if (r_phase == P_MAIN_IDLE) begin
                    n_phase         = P_MAIN;
                    n_res.access_op = OP_RD_SR;
                end
            end
            KIND_DONE: begin
                unique case (r_phase)
                    P_MAIN, P_CLOSE_WAIT: begin
                        if (st != ST_CLOSED) begin
                            if (r_phase == P_MAIN) begin
                                n_phase              = P_CLOSE;
                                n_res.access_op      = OP_WR_CR;
                                n_res.socket_command = CMD_CLOSE;
                            end else begin
                                n_phase         = P_CLOSE_WAIT;
                                n_res.access_op = OP_RD_SR;
                            end
                        end else begin
                            n_phase            = P_PORT;
                            n_res.access_op    = OP_WR_PORT;
                            n_res.access_value = i_cfg.listen_port;
                        end
                    end
                    P_CLOSE: begin
                        n_phase         = P_CLOSE_WAIT;
                        n_res.access_op = OP_RD_SR;
                    end
                    P_PORT: begin
                        n_phase            = P_MODE;
                        n_res.access_op    = OP_WR_MODE;
                        n_res.access_value = MODE_TCP;
                    end
                    P_MODE: begin
                        n_phase            = P_KEEP;
                        n_res.access_op    = OP_WR_KEEP;
                        n_res.access_value = {8'd0, i_cfg.keepalive_interval};
                    end
                    P_KEEP: begin
                        n_phase              = P_OPEN;
                        n_res.access_op      = OP_WR_CR;
                        n_res.socket_command = CMD_OPEN;
                    end
                    P_OPEN: begin
                        n_phase         = P_WAIT_OPEN;
                        n_res.access_op = OP_RD_SR;
                    end
                    P_WAIT_OPEN: begin
                        if (st != ST_INIT) begin
                            n_phase         = P_WAIT_OPEN;
                            n_res.access_op = OP_RD_SR;
                        end else begin
                            n_phase              = P_LISTEN_CMD;
                            n_res.access_op      = OP_WR_CR;
                            n_res.socket_command = CMD_LISTEN;
                        end
                    end
                    P_LISTEN_CMD: begin
                        n_phase         = P_LISTEN;
                        n_res.access_op = OP_RD_SR;
                    end
                    P_LISTEN: begin
                        n_res.access_op = OP_RD_SR;
                        if (st == ST_ESTAB) begin
                            n_tx_pend       = 1'b0;
                            n_conn          = 1'b1;
                            n_res.event_res = EV_CONN;
                            n_phase         = P_EST;
                        end else if (st_down) begin
                            n_phase = P_MAIN;
                        end else begin
                            n_phase = P_LISTEN;
                        end
                    end
                    P_EST: begin
                        if (st_down) begin
                            n_disc_pend     = 1'b0;
                            n_conn          = 1'b0;
                            n_res.event_res = EV_DISC;
                            n_phase         = P_MAIN;
                            n_res.access_op = OP_RD_SR;
                        end else if (r_disc_pend) begin
                            n_disc_pend          = 1'b0;
                            n_tx_pend            = 1'b0;
                            n_conn               = 1'b0;
                            n_res.event_res      = EV_DISC;
                            n_phase              = P_CLOSE;
                            n_res.access_op      = OP_WR_CR;
                            n_res.socket_command = CMD_CLOSE;
                        end else if (r_tx_pend) begin
                            n_phase         = P_TXF1;
                            n_res.access_op = OP_RD_TXFREE;
                        end else begin
                            n_phase         = P_RXS1;
                            n_res.access_op = OP_RD_RXSZ;
                        end
                    end
                    P_RXS1: begin
                        n_rx_count = v;
                        if (v == 16'd0) begin
                            n_phase         = P_EST;
                            n_res.access_op = OP_RD_SR;
                        end else begin
                            n_phase         = P_RXS2;
                            n_res.access_op = OP_RD_RXSZ;
                        end
                    end
                    P_RXS2: begin
                        if (r_rx_count != v) begin
                            n_phase         = P_RXS1;
                            n_res.access_op = OP_RD_RXSZ;
                        end else begin
                            if (r_rx_count > i_cfg.rx_capacity) begin
                                n_rx_count = i_cfg.rx_capacity;
                            end
                            n_phase         = P_RXPTR;
                            n_res.access_op = OP_RD_RXPTR;
                        end
                    end
                    P_RXPTR: begin
                        n_rx_ptr            = v;
                        n_phase             = P_RXDATA;
                        n_res.access_op     = OP_RD_RXBLK;
                        n_res.access_value  = v;
                        n_res.access_length = r_rx_count;
                    end
                    P_RXDATA: begin
                        n_phase            = P_RXWP;
                        n_res.access_op    = OP_WR_RXPTR;
                        n_res.access_value = 16'(r_rx_ptr + r_rx_count);
                    end
                    P_RXWP: begin
                        n_phase              = P_RECV;
                        n_res.access_op      = OP_WR_CR;
                        n_res.socket_command = CMD_RECV;
                    end
                    P_RECV: begin
                        n_phase         = P_RECV_POLL;
                        n_res.access_op = OP_RD_CR;
                    end
                    P_RECV_POLL: begin
                        if (st == 8'd0) begin
                            n_res.event_res    = EV_RX;
                            n_res.event_length = r_rx_count;
                            n_phase            = P_EST;
                            n_res.access_op    = OP_RD_SR;
                        end else begin
                            n_phase         = P_RECV_POLL;
                            n_res.access_op = OP_RD_CR;
                        end
                    end
                    P_TXF1: begin
                        n_tx_free       = v;
                        n_phase         = P_TXF2;
                        n_res.access_op = OP_RD_TXFREE;
                    end
                    P_TXF2: begin
                        if (r_tx_free != v) begin
                            n_phase         = P_TXF1;
                            n_res.access_op = OP_RD_TXFREE;
                        end else if (v < r_tx_len) begin
                            n_phase         = P_EST;
                            n_res.access_op = OP_RD_SR;
                        end else begin
                            n_phase         = P_TXPTR;
                            n_res.access_op = OP_RD_TXPTR;
                        end
                    end
                    P_TXPTR: begin
                        n_tx_ptr            = v;
                        n_phase             = P_TXDATA;
                        n_res.access_op     = OP_WR_TXBLK;
                        n_res.access_value  = v;
                        n_res.access_length = r_tx_len;
                    end
                    P_TXDATA: begin
                        n_phase            = P_TXWP;
                        n_res.access_op    = OP_WR_TXPTR;
                        n_res.access_value = 16'(r_tx_ptr + r_tx_len);
                    end
                    P_TXWP: begin
                        n_phase              = P_SEND;
                        n_res.access_op      = OP_WR_CR;
                        n_res.socket_command = CMD_SEND;
                    end
                    P_SEND: begin
                        n_phase         = P_SEND_POLL;
                        n_res.access_op = OP_RD_CR;
                    end
                    P_SEND_POLL: begin
                        if (st == 8'd0) begin
                            n_phase         = P_IRR;
                            n_res.access_op = OP_CLR_SENDOK;
                        end else begin
                            n_phase         = P_SEND_POLL;
                            n_res.access_op = OP_RD_CR;
                        end
                    end
                    P_IRR: begin
                        n_tx_pend       = 1'b0;
                        n_res.event_res = EV_TX;
                        n_phase         = P_EST;
                        n_res.access_op = OP_RD_SR;
                    end
                    default: ;
                endcase
            end
            KIND_TX: begin
                if (r_tx_pend) begin
                    n_res.request_rejected = 1'b1;
                end else begin
                    n_tx_len  = i_item.send_length;
                    n_tx_pend = 1'b1;
                end
            end
            KIND_DISC: begin
                if (!r_conn) begin
                    n_res.request_rejected = 1'b1;
                end else begin
                    n_disc_pend = 1'b1;
                end
            end
            default: ;
        endcase

        n_res.link_up    = n_conn;
        n_res.send_ready = !n_tx_pend;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= P_MAIN_IDLE;
            r_rx_count  <= 16'd0;
            r_rx_ptr    <= 16'd0;
            r_tx_free   <= 16'd0;
            r_tx_ptr    <= 16'd0;
            r_tx_len    <= 16'd0;
            r_tx_pend   <= 1'b0;
            r_disc_pend <= 1'b0;
            r_conn      <= 1'b0;
        end else if (i_step) begin
            r_phase     <= n_phase;
            r_rx_count  <= n_rx_count;
            r_rx_ptr    <= n_rx_ptr;
            r_tx_free   <= n_tx_free;
            r_tx_ptr    <= n_tx_ptr;
            r_tx_len    <= n_tx_len;
            r_tx_pend   <= n_tx_pend;
            r_disc_pend <= n_disc_pend;
            r_conn      <= n_conn;
            r_res       <= n_res;
        end
    end

endmodule

// ===== sv/tcp_server_socket_sequencer.sv =====
// ----------------------------------------------------------------------------
// tcp_server_socket_sequencer
// Server socket sequencer: turns socket events into register accesses.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_stall / i_in_data) carries one beat per
//   start kick, completed access (with its read value), transmit request or
//   disconnect request. Output channel (o_out_valid / i_out_stall /
//   o_out_data) returns exactly one beat per input: the next access to
//   issue plus any event and the link/send status after the step.
//   Config channel (i_cfg_valid / o_cfg_ready / i_cfg_index / i_cfg_data)
//   writes listen port, rx capacity and keepalive; write only while idle.
//   The input register feeds the step logic (compares and 16-bit pointer
//   adds), which feeds the result register. Throughput is one beat per
//   cycle while the receiver does not stall.
//   When the receiver stalls, the result holds and the input register holds
//   one more beat; o_in_stall rises only when both are full.
//   Reset (synchronous, active low) empties both stages, returns the
//   sequencer to waiting for a start kick and loads the default config.
// ----------------------------------------------------------------------------
module tcp_server_socket_sequencer (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  tss_pkg::t_in_item  i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output tss_pkg::t_out_item o_out_data,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [1:0]         i_cfg_index,
    input  logic [15:0]        i_cfg_data
);
    import tss_pkg::*;

    logic     r_in_valid;
    t_in_item r_in_item;
    logic     r_out_valid;
    logic     out_free;
    logic     step;
    logic     in_take;
    t_cfg     cfg;

    assign out_free    = !r_out_valid || !i_out_stall;
    assign step        = r_in_valid && out_free;
    assign o_in_stall  = r_in_valid && !out_free;
    assign in_take     = i_in_valid && !o_in_stall;
    assign o_out_valid = r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_take) begin
                r_in_valid <= 1'b1;
            end else if (step) begin
                r_in_valid <= 1'b0;
            end
            if (step) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
        if (in_take) begin
            r_in_item <= i_in_data;
        end
    end

    tss_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg_ready (o_cfg_ready),
        .o_cfg       (cfg)
    );

    tss_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (step),
        .i_item  (r_in_item),
        .i_cfg   (cfg),
        .o_res   (o_out_data)
    );

endmodule

// ===== sim/tb_tcp_server_socket_sequencer.sv =====
// ----------------------------------------------------------------------------
// tb_tcp_server_socket_sequencer
// Self-checking bench for the TCP server socket sequencer.
// A beat-level predictor of the socket state machine runs alongside the
// block. It computes the next register access, event and status flags for
// every accepted input beat. A directed bring-up covers start/idle handling,
// socket setup, listen polling, a zero-capacity receive and a peer close
// with a transmit pending. Randomized traffic then plays a register file
// that answers each access plausibly, with some noise mixed in. It runs
// under several configurations, all but one with input gaps and output stalls.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_tcp_server_socket_sequencer;

    import tss_pkg::*;

    typedef enum logic [5:0] {
        PH_IDLE, PH_MAIN, PH_CLOSE, PH_CLOSE_WAIT, PH_PORT, PH_MODE, PH_KEEP,
        PH_OPEN, PH_WAIT_OPEN, PH_LISTEN_CMD, PH_LISTEN, PH_EST, PH_RXS1,
        PH_RXS2, PH_RXPTR, PH_RXDATA, PH_RXWP, PH_RECV, PH_RECV_POLL,
        PH_TXF1, PH_TXF2, PH_TXPTR, PH_TXDATA, PH_TXWP, PH_SEND,
        PH_SEND_POLL, PH_IRR
    } t_seq_phase;

    logic       i_clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    t_in_item   in_data = '0;
    logic       out_stall = 1'b0;
    logic       cfg_valid = 1'b0;
    logic [1:0] cfg_index = REG_LISTEN_PORT;
    logic [15:0] cfg_data = '0;

    logic       in_stall;
    logic       out_valid;
    t_out_item  out_data;
    logic       cfg_ready;

    tcp_server_socket_sequencer i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // socket model state
    logic [15:0] cfg_port = 16'd0;
    logic [15:0] cfg_cap  = 16'd2048;
    logic [7:0]  cfg_keep = 8'd2;

    t_seq_phase  seq_ph = PH_IDLE;
    logic [15:0] rx_cnt = '0;
    logic [15:0] rx_cnt_chk = '0;
    logic [15:0] rx_ptr = '0;
    logic [15:0] txf_first = '0;
    logic [15:0] tx_ptr = '0;
    logic [15:0] tx_len = '0;
    logic        tx_pend = 1'b0;
    logic        disc_pend = 1'b0;
    logic        linked = 1'b0;
    t_out_item   step_out;

    t_out_item   access_q[$];
    int unsigned mism = 0;
    logic        calm = 1'b0;

    function automatic void issue(t_seq_phase nxt, logic [3:0] op, logic [2:0] cmd,
                                  logic [15:0] val, logic [15:0] len);
        seq_ph = nxt;
        step_out.access_op = op;
        step_out.socket_command = cmd;
        step_out.access_value = val;
        step_out.access_length = len;
    endfunction

    function automatic void issue_rd(t_seq_phase nxt, logic [3:0] op);
        issue(nxt, op, '0, '0, '0);
    endfunction

    function automatic void issue_cmd(t_seq_phase nxt, logic [2:0] cmd);
        issue(nxt, OP_WR_CR, cmd, '0, '0);
    endfunction

    function automatic logic is_down(logic [7:0] st);
        return st == ST_CLOSED || st == ST_INIT || st == ST_CLOSE_WAIT;
    endfunction

    function automatic void complete(logic [15:0] v);
        logic [7:0] st;
        st = v[7:0];
        case (seq_ph)
            PH_MAIN, PH_CLOSE_WAIT: begin
                if (st != ST_CLOSED) begin
                    if (seq_ph == PH_MAIN) issue_cmd(PH_CLOSE, CMD_CLOSE);
                    else issue_rd(PH_CLOSE_WAIT, OP_RD_SR);
                end else begin
                    issue(PH_PORT, OP_WR_PORT, '0, cfg_port, '0);
                end
            end
            PH_CLOSE:      issue_rd(PH_CLOSE_WAIT, OP_RD_SR);
            PH_PORT:       issue(PH_MODE, OP_WR_MODE, '0, MODE_TCP, '0);
            PH_MODE:       issue(PH_KEEP, OP_WR_KEEP, '0, {8'h00, cfg_keep}, '0);
            PH_KEEP:       issue_cmd(PH_OPEN, CMD_OPEN);
            PH_OPEN:       issue_rd(PH_WAIT_OPEN, OP_RD_SR);
            PH_WAIT_OPEN: begin
                if (st != ST_INIT) issue_rd(PH_WAIT_OPEN, OP_RD_SR);
                else issue_cmd(PH_LISTEN_CMD, CMD_LISTEN);
            end
            PH_LISTEN_CMD: issue_rd(PH_LISTEN, OP_RD_SR);
            PH_LISTEN: begin
                if (st == ST_ESTAB) begin
                    tx_pend = 1'b0;
                    linked = 1'b1;
                    step_out.event_res = EV_CONN;
                    issue_rd(PH_EST, OP_RD_SR);
                end else if (is_down(st)) begin
                    issue_rd(PH_MAIN, OP_RD_SR);
                end else begin
                    issue_rd(PH_LISTEN, OP_RD_SR);
                end
            end
            PH_EST: begin
                if (is_down(st)) begin
                    disc_pend = 1'b0;
                    linked = 1'b0;
                    step_out.event_res = EV_DISC;
                    issue_rd(PH_MAIN, OP_RD_SR);
                end else if (disc_pend) begin
                    disc_pend = 1'b0;
                    tx_pend = 1'b0;
                    linked = 1'b0;
                    step_out.event_res = EV_DISC;
                    issue_cmd(PH_CLOSE, CMD_CLOSE);
                end else if (tx_pend) begin
                    issue_rd(PH_TXF1, OP_RD_TXFREE);
                end else begin
                    issue_rd(PH_RXS1, OP_RD_RXSZ);
                end
            end
            PH_RXS1: begin
                rx_cnt = v;
                if (v == 16'd0) issue_rd(PH_EST, OP_RD_SR);
                else issue_rd(PH_RXS2, OP_RD_RXSZ);
            end
            PH_RXS2: begin
                rx_cnt_chk = v;
                if (rx_cnt != rx_cnt_chk) begin
                    issue_rd(PH_RXS1, OP_RD_RXSZ);
                end else begin
                    if (rx_cnt > cfg_cap) rx_cnt = cfg_cap;
                    issue_rd(PH_RXPTR, OP_RD_RXPTR);
                end
            end
            PH_RXPTR: begin
                rx_ptr = v;
                issue(PH_RXDATA, OP_RD_RXBLK, '0, rx_ptr, rx_cnt);
            end
            PH_RXDATA:     issue(PH_RXWP, OP_WR_RXPTR, '0, rx_ptr + rx_cnt, '0);
            PH_RXWP:       issue_cmd(PH_RECV, CMD_RECV);
            PH_RECV:       issue_rd(PH_RECV_POLL, OP_RD_CR);
            PH_RECV_POLL: begin
                if (st == 8'h00) begin
                    step_out.event_res = EV_RX;
                    step_out.event_length = rx_cnt;
                    issue_rd(PH_EST, OP_RD_SR);
                end else begin
                    issue_rd(PH_RECV_POLL, OP_RD_CR);
                end
            end
            PH_TXF1: begin
                txf_first = v;
                issue_rd(PH_TXF2, OP_RD_TXFREE);
            end
            PH_TXF2: begin
                if (txf_first != v) issue_rd(PH_TXF1, OP_RD_TXFREE);
                else if (v < tx_len) issue_rd(PH_EST, OP_RD_SR);
                else issue_rd(PH_TXPTR, OP_RD_TXPTR);
            end
            PH_TXPTR: begin
                tx_ptr = v;
                issue(PH_TXDATA, OP_WR_TXBLK, '0, tx_ptr, tx_len);
            end
            PH_TXDATA:     issue(PH_TXWP, OP_WR_TXPTR, '0, tx_ptr + tx_len, '0);
            PH_TXWP:       issue_cmd(PH_SEND, CMD_SEND);
            PH_SEND:       issue_rd(PH_SEND_POLL, OP_RD_CR);
            PH_SEND_POLL: begin
                if (st == 8'h00) issue_rd(PH_IRR, OP_CLR_SENDOK);
                else issue_rd(PH_SEND_POLL, OP_RD_CR);
            end
            PH_IRR: begin
                tx_pend = 1'b0;
                step_out.event_res = EV_TX;
                issue_rd(PH_EST, OP_RD_SR);
            end
            default: ;
        endcase
    endfunction

    function automatic t_out_item next_access(t_in_item it);
        step_out = '0;
        step_out.access_op = OP_NONE;
        step_out.event_res = EV_NONE;
        case (it.kind)
            KIND_START: if (seq_ph == PH_IDLE) issue_rd(PH_MAIN, OP_RD_SR);
            KIND_DONE:  if (seq_ph != PH_IDLE) complete(it.read_value);
            KIND_TX: begin
                if (tx_pend) begin
                    step_out.request_rejected = 1'b1;
                end else begin
                    tx_len = it.send_length;
                    tx_pend = 1'b1;
                end
            end
            default: begin
                if (!linked) step_out.request_rejected = 1'b1;
                else disc_pend = 1'b1;
            end
        endcase
        step_out.link_up = linked;
        step_out.send_ready = !tx_pend;
        return step_out;
    endfunction

    // register file stand-in: plausible read data for the access in flight
    function automatic logic [7:0] pick_status(int unsigned pct, logic [7:0] usual);
        logic [7:0] st;
        if ($urandom_range(99) < pct) return usual;
        case ($urandom_range(4))
            0: st = ST_CLOSED;
            1: st = ST_INIT;
            2: st = ST_ESTAB;
            3: st = ST_CLOSE_WAIT;
            default: st = 8'($urandom);
        endcase
        return st;
    endfunction

    function automatic logic [15:0] reply_value();
        logic [15:0] w;
        w = 16'($urandom);
        case (seq_ph)
            PH_MAIN:       w[7:0] = pick_status(50, ST_CLOSED);
            PH_CLOSE_WAIT: w[7:0] = pick_status(70, ST_CLOSED);
            PH_WAIT_OPEN:  w[7:0] = pick_status(75, ST_INIT);
            PH_LISTEN:     w[7:0] = pick_status(55, ST_ESTAB);
            PH_EST:        w[7:0] = pick_status(88, ST_ESTAB);
            PH_RXS1: begin
                if ($urandom_range(99) < 30) w = '0;
                else if ($urandom_range(1)) w = 16'($urandom_range(4095, 1));
            end
            PH_RXS2:       if ($urandom_range(99) < 80) w = rx_cnt;
            PH_TXF1: begin
                if ($urandom_range(99) < 75) w = 16'($urandom_range(16'hFFFF, tx_len));
            end
            PH_TXF2:       if ($urandom_range(99) < 80) w = txf_first;
            PH_RXPTR, PH_TXPTR: begin
                if ($urandom_range(1)) w = 16'($urandom_range(16'hFFFF, 16'hF000));
            end
            PH_RECV_POLL, PH_SEND_POLL: begin
                if ($urandom_range(99) < 65) w[7:0] = 8'h00;
                else w[7:0] = 8'($urandom_range(255, 1));
            end
            default: ;
        endcase
        return w;
    endfunction

    function automatic t_in_item rand_beat();
        t_in_item    it;
        int unsigned p;
        it.read_value = 16'($urandom);
        it.send_length = 16'($urandom);
        p = $urandom_range(99);
        if (p < 78) begin
            it.kind = KIND_DONE;
            it.read_value = reply_value();
        end else if (p < 86) begin
            it.kind = KIND_DONE;
        end else if (p < 92) begin
            it.kind = KIND_TX;
            if ($urandom_range(99) < 70) it.send_length = 16'($urandom_range(2000, 0));
        end else if (p < 96) begin
            it.kind = KIND_DISC;
        end else begin
            it.kind = KIND_START;
        end
        return it;
    endfunction

    task automatic send_beat(input t_in_item it, output logic counted);
        t_out_item want;
        while (!calm && $urandom_range(99) < 24) begin
            in_valid <= 1'b0;
            @(posedge i_clk);
        end
        want = next_access(it);
        access_q.push_back(want);
        counted = !(want.access_op == OP_NONE && (it.kind == KIND_START || it.kind == KIND_DONE));
        in_valid <= 1'b1;
        in_data <= it;
        do @(posedge i_clk); while (in_stall);
    endtask

    task automatic put(logic [1:0] kind, logic [15:0] rv, logic [15:0] len);
        t_in_item it;
        logic     counted;
        it.kind = kind;
        it.read_value = rv;
        it.send_length = len;
        send_beat(it, counted);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (access_q.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [15:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do @(posedge i_clk); while (!cfg_ready);
        case (idx)
            REG_LISTEN_PORT: cfg_port = data;
            REG_RX_CAPACITY: cfg_cap = data;
            default:         cfg_keep = data[7:0];
        endcase
    endtask

    task automatic set_config(logic [15:0] port, logic [15:0] cap, logic [7:0] keep);
        logic [7:0] junk;
        junk = 8'($urandom);
        write_reg(REG_LISTEN_PORT, port);
        write_reg(REG_RX_CAPACITY, cap);
        write_reg(REG_KEEPALIVE, {junk, keep});
        cfg_valid <= 1'b0;
    endtask

    task automatic test_directed();
        set_config(16'hFFFF, 16'h0000, 8'hFF);
        put(KIND_DONE, 16'h0017, 16'h0000);     // completion before start: ignored
        put(KIND_TX, 16'h0000, 16'hFFFF);       // accepted while not connected
        put(KIND_TX, 16'hFFFF, 16'h0005);       // already pending: refused
        put(KIND_DISC, 16'h0000, 16'h0000);     // not connected: refused
        put(KIND_START, 16'h0000, 16'h0000);
        put(KIND_START, 16'h0000, 16'h0000);    // already running: ignored
        put(KIND_DONE, {8'hA5, ST_ESTAB}, 16'h0000);
        put(KIND_DONE, 16'h0000, 16'h0000);
        put(KIND_DONE, {8'h00, ST_INIT}, 16'h0000);
        put(KIND_DONE, {8'hFF, ST_CLOSED}, 16'h0000);
        put(KIND_DONE, 16'h0000, 16'h0000);
        put(KIND_DONE, 16'h0000, 16'h0000);
        put(KIND_DONE, 16'h0000, 16'h0000);
        put(KIND_DONE, 16'h0000, 16'h0000);
        put(KIND_DONE, {8'h00, ST_INIT}, 16'h0000);
        put(KIND_DONE, 16'h0000, 16'h0000);
        put(KIND_DONE, 16'h0042, 16'h0000);     // unknown listen status: poll again
        put(KIND_DONE, {8'h5A, ST_ESTAB}, 16'h0000); // connect clears the transmit
        put(KIND_DONE, {8'h00, ST_ESTAB}, 16'h0000);
        put(KIND_TX, 16'h0000, 16'h0010);
        put(KIND_DONE, 16'h0100, 16'h0000);
        put(KIND_DONE, 16'h0100, 16'h0000);     // zero capacity clamps to empty block
        put(KIND_DONE, 16'hFFF0, 16'h0000);
        put(KIND_DONE, 16'h0000, 16'h0000);
        put(KIND_DONE, 16'h0000, 16'h0000);
        put(KIND_DONE, 16'h0000, 16'h0000);
        put(KIND_DONE, 16'hFF00, 16'h0000);
        put(KIND_DONE, {8'h00, ST_CLOSE_WAIT}, 16'h0000); // peer close, transmit stays
    endtask

    task automatic test_traffic(int unsigned n, logic [15:0] port, logic [15:0] cap,
                                logic [7:0] keep, logic quiet);
        int unsigned done_n;
        logic        counted;
        done_n = 0;
        wait_drained();
        set_config(port, cap, keep);
        calm = quiet;
        while (done_n < n) begin
            send_beat(rand_beat(), counted);
            if (counted) done_n++;
            if (done_n == n / 2 && counted) wait_drained();
        end
        calm = 1'b0;
    endtask

    function automatic void chk(string name, logic [15:0] want, logic [15:0] got);
        if (got !== want) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            mism++;
        end
    endfunction

    always @(posedge i_clk) begin
        t_out_item want;
        out_stall <= !calm && ($urandom_range(99) < 24);
        if (rst_n && out_valid && !out_stall) begin
            if (access_q.size() == 0) begin
                $error("result beat with nothing expected");
                mism++;
            end else begin
                want = access_q.pop_front();
                chk("access_op", want.access_op, out_data.access_op);
                chk("socket_command", want.socket_command, out_data.socket_command);
                chk("access_value", want.access_value, out_data.access_value);
                chk("access_length", want.access_length, out_data.access_length);
                chk("event_res", want.event_res, out_data.event_res);
                chk("event_length", want.event_length, out_data.event_length);
                chk("link_up", want.link_up, out_data.link_up);
                chk("send_ready", want.send_ready, out_data.send_ready);
                chk("request_rejected", want.request_rejected, out_data.request_rejected);
            end
        end
    end

    initial begin
        repeat (12) @(posedge i_clk);
        rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_traffic(400, 16'h0000, 16'hFFFF, 8'h00, 1'b0);
        test_traffic(400, 16'($urandom), 16'($urandom_range(300, 1)), 8'($urandom), 1'b1);
        test_traffic(400, 16'($urandom), 16'd2048, 8'd2, 1'b0);
        wait_drained();
        repeat (8) @(posedge i_clk);
        if (mism == 0) begin
            $display("[tcp_server_socket_sequencer] OK");
        end else begin
            $display("[tcp_server_socket_sequencer] ERROR");
        end
        $finish;
    end

    initial begin
        #4_000_000;
        $display("[tcp_server_socket_sequencer] ERROR");
        $finish;
    end

endmodule
